/* hw/rtl/gray_box_blur_3x3_top_assert.svh */
// assertion macros shared by the gray box blur rtl
// expects i_clk and i_rst_n in the scope of each use
`ifndef GRAY_BOX_BLUR_3X3_TOP_ASSERT_SVH
`define GRAY_BOX_BLUR_3X3_TOP_ASSERT_SVH

// expression holds at every clock edge out of reset
`define GBB_ASSERT_HOLDS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define GBB_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define GBB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/gbb_pkg.sv */
// shared constants, codes and types of the gray box blur
// no dependencies
package gbb_pkg;

    // frame geometry limits
    localparam int MAX_WIDTH    = 2048;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int PIXEL_BITS   = 8;

    // register and stream field widths
    localparam int WIDTH_BITS  = 12;
    localparam int HEIGHT_BITS = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_IDX_W   = 1;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 8;

    // counter widths
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(HEIGHT_LIMIT);
    localparam int WU_W  = $clog2(MAX_WIDTH + 1);
    localparam int HU_W  = $clog2(HEIGHT_LIMIT + 1);
    localparam int POS_W = $clog2(MAX_WIDTH * HEIGHT_LIMIT + MAX_WIDTH + 2);

    // color sum and divide by 3 through a reciprocal
    localparam int RAW_W    = PIXEL_BITS + 2;
    localparam int DIV3_SH  = PIXEL_BITS + 3;
    localparam int DIV3_MUL = (2 ** DIV3_SH + 2) / 3;
    localparam int D3P_W    = RAW_W + DIV3_SH;

    // window sum and divide by 9 through a reciprocal
    localparam int WSUM_W   = PIXEL_BITS + 4;
    localparam int DIV9_SH  = PIXEL_BITS + 7;
    localparam int DIV9_MUL = (2 ** DIV9_SH + 8) / 9;
    localparam int D9P_W    = WSUM_W + DIV9_SH;

    // result queue
    localparam int OUTQ_AW    = 3;
    localparam int OUTQ_DEPTH = 2 ** OUTQ_AW;
    localparam int CNT_W      = OUTQ_AW + 1;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

    // item kinds
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // per-item control decided at acceptance
    typedef struct packed {
        logic emit;
        logic border;
        logic last_col;
        logic last_frame;
    } t_ctl;

    // one result
    typedef struct packed {
        logic [PIXEL_BITS-1:0] gray_value;
        logic                  end_of_row;
        logic                  end_of_frame;
    } t_result;

endpackage

/* hw/rtl/gbb_ram.sv */
// generic simple dual port ram, one write and one registered read port
// no dependencies
module gbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and read-first registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

/* hw/rtl/gbb_seq.sv */
// configuration registers, frame counters and per-request decisions
// depends on gbb_pkg
module gbb_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [gbb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gbb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_accept,
    input  logic                          i_opcode,
    output logic                          o_hold,
    output logic                          o_take,
    output logic [gbb_pkg::COL_W-1:0]     o_col,
    output gbb_pkg::t_ctl                 o_ctl
);
    import gbb_pkg::*;

    logic [WIDTH_BITS-1:0]  r_width;
    logic [HEIGHT_BITS-1:0] r_height;
    logic                   r_hold;

    logic [WU_W-1:0]  w_used;
    logic [HU_W-1:0]  h_used;
    logic [WU_W-1:0]  r_w;
    logic [COL_W-1:0] r_w_m1;
    logic [ROW_W-1:0] r_h_m1;
    logic [POS_W-1:0] r_total;

    logic [COL_W-1:0] r_in_col,  n_in_col;
    logic [POS_W-1:0] r_in_pos,  n_in_pos;
    logic [COL_W-1:0] r_out_col, n_out_col;
    logic [ROW_W-1:0] r_out_row, n_out_row;
    logic [POS_W-1:0] r_out_pos, n_out_pos;

    logic in_done;
    logic take;
    t_ctl ctl;

    // configuration registers, input held off in the cycle after a write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_BITS'(640);
            r_height <= HEIGHT_BITS'(480);
            r_hold   <= 1'b1;
        end else begin
            r_hold <= i_cfg_we;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data[WIDTH_BITS-1:0];
                    CFG_IMAGE_HEIGHT: r_height <= i_cfg_data[HEIGHT_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    // clamp registers to usable geometry
    always_comb begin
        if (r_width == '0) begin
            w_used = WU_W'(1);
        end else if (int'(r_width) > MAX_WIDTH) begin
            w_used = WU_W'(MAX_WIDTH);
        end else begin
            w_used = WU_W'(r_width);
        end
        if (r_height == '0) begin
            h_used = HU_W'(1);
        end else if (int'(r_height) > HEIGHT_LIMIT) begin
            h_used = HU_W'(HEIGHT_LIMIT);
        end else begin
            h_used = HU_W'(r_height);
        end
    end

    // derived geometry, refreshed every cycle
    always_ff @(posedge i_clk) begin
        r_w     <= w_used;
        r_w_m1  <= COL_W'(w_used - WU_W'(1));
        r_h_m1  <= ROW_W'(h_used - HU_W'(1));
        r_total <= POS_W'(w_used) * POS_W'(h_used);
    end

    // decide what the accepted request does
    always_comb begin
        in_done        = (r_in_pos >= r_total);
        take           = i_accept && ((i_opcode == OP_DRAIN) ? in_done : !in_done);
        ctl.emit       = take && (r_in_pos > POS_W'(r_w));
        ctl.last_col   = (r_out_col == r_w_m1);
        ctl.last_frame = ((r_out_pos + POS_W'(1)) == r_total);
        ctl.border     = (r_out_row == '0) || (r_out_row == r_h_m1) ||
                         (r_out_col == '0) || ctl.last_col;
    end

    // next counter values
    always_comb begin
        n_in_col  = r_in_col;
        n_in_pos  = r_in_pos;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_out_pos = r_out_pos;
        if (i_cfg_we) begin
            n_in_col  = '0;
            n_in_pos  = '0;
            n_out_col = '0;
            n_out_row = '0;
            n_out_pos = '0;
        end else if (take) begin
            n_in_col = (r_in_col == r_w_m1) ? '0 : r_in_col + COL_W'(1);
            n_in_pos = r_in_pos + POS_W'(1);
            if (ctl.emit) begin
                if (ctl.last_frame) begin
                    n_in_col  = '0;
                    n_in_pos  = '0;
                    n_out_col = '0;
                    n_out_row = '0;
                    n_out_pos = '0;
                end else begin
                    n_out_pos = r_out_pos + POS_W'(1);
                    if (ctl.last_col) begin
                        n_out_col = '0;
                        n_out_row = r_out_row + ROW_W'(1);
                    end else begin
                        n_out_col = r_out_col + COL_W'(1);
                    end
                end
            end
        end
    end

    // frame counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_pos  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_out_pos <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_pos  <= n_in_pos;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_out_pos <= n_out_pos;
        end
    end

    assign o_hold = r_hold;
    assign o_take = take;
    assign o_col  = r_in_col;
    assign o_ctl  = ctl;

endmodule

/* hw/rtl/gbb_win.sv */
// line stores, 3x3 window and the gray and blur arithmetic
// depends on gbb_pkg and gbb_ram
module gbb_win (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_take,
    input  logic [gbb_pkg::COL_W-1:0]      i_col,
    input  gbb_pkg::t_ctl                  i_ctl,
    input  logic [gbb_pkg::PIXEL_BITS-1:0] i_red,
    input  logic [gbb_pkg::PIXEL_BITS-1:0] i_green,
    input  logic [gbb_pkg::PIXEL_BITS-1:0] i_blue,
    output logic                           o_res_valid,
    output gbb_pkg::t_result               o_res,
    output logic [1:0]                     o_inflight
);
    import gbb_pkg::*;

    // stage 1: line store read data arrives
    logic                  r_s1_valid;
    logic [COL_W-1:0]      r_s1_col;
    logic [RAW_W-1:0]      r_s1_sum;
    t_ctl                  r_s1_ctl;
    logic                  r_s1_fwd;
    logic [PIXEL_BITS-1:0] r_fwd_a;
    logic [PIXEL_BITS-1:0] r_fwd_b;
    logic [PIXEL_BITS-1:0] a_rd;
    logic [PIXEL_BITS-1:0] b_rd;
    logic [D3P_W-1:0]      gray_prod;
    logic [PIXEL_BITS-1:0] s1_gray;
    logic [PIXEL_BITS-1:0] s1_a;
    logic [PIXEL_BITS-1:0] s1_b;

    // stage 2: window sum
    logic [PIXEL_BITS-1:0] r_win [3][3];
    logic                  r_s2_valid;
    t_ctl                  r_s2_ctl;
    logic [WSUM_W-1:0]     win_sum;

    // stage 3: divide by 9 and select
    logic                  r_s3_valid;
    t_ctl                  r_s3_ctl;
    logic [WSUM_W-1:0]     r_s3_sum;
    logic [PIXEL_BITS-1:0] r_s3_center;
    logic [D9P_W-1:0]      blur_prod;

    // stage 1 capture at acceptance, forward when the previous request hit the same column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_take;
        end
        r_s1_col <= i_col;
        r_s1_sum <= RAW_W'(i_red) + RAW_W'(i_green) + RAW_W'(i_blue);
        r_s1_ctl <= i_ctl;
        r_s1_fwd <= r_s1_valid && (r_s1_col == i_col);
        r_fwd_a  <= s1_gray;
        r_fwd_b  <= s1_a;
    end

    // gray level and effective line store values
    always_comb begin
        gray_prod = D3P_W'(r_s1_sum) * D3P_W'(DIV3_MUL);
        s1_gray   = gray_prod[DIV3_SH +: PIXEL_BITS];
        s1_a      = r_s1_fwd ? r_fwd_a : a_rd;
        s1_b      = r_s1_fwd ? r_fwd_b : b_rd;
    end

    // row above: read at acceptance, rewritten with the new gray
    gbb_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_row_above (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (s1_gray),
        .i_re    (i_take),
        .i_raddr (i_col),
        .o_rdata (a_rd)
    );

    // row two above: takes over the old row above entry
    gbb_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_row_two_above (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (s1_a),
        .i_re    (i_take),
        .i_raddr (i_col),
        .o_rdata (b_rd)
    );

    // window shift, newest column on the right
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid && r_s1_ctl.emit;
            if (r_s1_valid) begin
                for (int r = 0; r < 3; r++) begin
                    r_win[r][0] <= r_win[r][1];
                    r_win[r][1] <= r_win[r][2];
                end
                r_win[0][2] <= s1_b;
                r_win[1][2] <= s1_a;
                r_win[2][2] <= s1_gray;
            end
        end
        r_s2_ctl <= r_s1_ctl;
    end

    // sum of the nine window entries
    always_comb begin
        win_sum = '0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                win_sum = win_sum + WSUM_W'(r_win[r][c]);
            end
        end
    end

    // stage 3 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2_valid;
        end
        r_s3_ctl    <= r_s2_ctl;
        r_s3_sum    <= win_sum;
        r_s3_center <= r_win[1][1];
    end

    // blur by reciprocal, border pixels keep their own gray
    always_comb begin
        blur_prod          = D9P_W'(r_s3_sum) * D9P_W'(DIV9_MUL);
        o_res.gray_value   = r_s3_ctl.border ? r_s3_center
                                             : blur_prod[DIV9_SH +: PIXEL_BITS];
        o_res.end_of_row   = r_s3_ctl.last_col;
        o_res.end_of_frame = r_s3_ctl.last_frame;
    end

    assign o_res_valid = r_s3_valid;
    assign o_inflight  = {1'b0, r_s1_valid && r_s1_ctl.emit} + {1'b0, r_s2_valid} +
                         {1'b0, r_s3_valid};

endmodule

/* hw/rtl/gbb_outq.sv */
// result queue between the blur pipeline and the output stream
// depends on gbb_pkg
module gbb_outq (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  gbb_pkg::t_result          i_data,
    input  logic                      i_ready,
    output logic                      o_valid,
    output gbb_pkg::t_result          o_data,
    output logic [gbb_pkg::CNT_W-1:0] o_count
);
    import gbb_pkg::*;

    t_result            r_mem [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0] r_wr_ptr;
    logic [OUTQ_AW-1:0] r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               pop;

    assign pop = (r_count != '0) && i_ready;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + OUTQ_AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + OUTQ_AW'(1);
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

/* hw/rtl/gray_box_blur_3x3_top.sv */
// Gray 3x3 box blur. Takes one RGB pixel (or drain request) per clock in raster
// order and returns one gray result per clock once the pipe is primed and while the
// output is ready. The result for a pixel is released when the pixel one row and one
// column later is accepted; after the last pixel of a frame, width + 1 drain requests
// push out the rest. Internally each request passes through the line store read,
// window and divide stages before entering an 8-entry result queue; input ready
// drops only when that queue plus the requests in flight would overflow, in the cycle
// after each register write and in the first cycle after reset. The two line stores
// are single-port-read rams with no reset and no clearing pass; their stale contents
// never reach a result.
// depends on gbb_pkg, gbb_seq, gbb_win, gbb_outq, gbb_ram and the assertion header
`include "gray_box_blur_3x3_top_assert.svh"

module gray_box_blur_3x3_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // pixel stream in
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [gbb_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,   // red, green, blue
    input  logic                           i_s_axis_tuser,   // opcode
    // result stream out
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [gbb_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,   // gray_value
    output logic                           o_m_axis_tlast,   // end_of_row
    output logic                           o_m_axis_tuser,   // end_of_frame
    // register writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [gbb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gbb_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import gbb_pkg::*;

    logic             cfg_we;
    logic             in_accept;
    logic             hold;
    logic             take;
    logic [COL_W-1:0] col;
    t_ctl             ctl;
    logic             res_valid;
    t_result          res;
    t_result          q_data;
    logic [1:0]       inflight;
    logic [CNT_W-1:0] q_count;
    logic [CNT_W-1:0] occupancy;
    logic             out_eof;

    // handshakes and flow control
    assign o_cfg_ready     = 1'b1;
    assign cfg_we          = i_cfg_valid && o_cfg_ready;
    assign occupancy       = q_count + CNT_W'(inflight);
    assign o_s_axis_tready = !hold && (int'(occupancy) < OUTQ_DEPTH);
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    // counters and decisions
    gbb_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (in_accept),
        .i_opcode    (i_s_axis_tuser),
        .o_hold      (hold),
        .o_take      (take),
        .o_col       (col),
        .o_ctl       (ctl)
    );

    // line stores and arithmetic
    gbb_win u_win (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_col       (col),
        .i_ctl       (ctl),
        .i_red       (i_s_axis_tdata[PIXEL_BITS-1:0]),
        .i_green     (i_s_axis_tdata[2*PIXEL_BITS-1:PIXEL_BITS]),
        .i_blue      (i_s_axis_tdata[3*PIXEL_BITS-1:2*PIXEL_BITS]),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_inflight  (inflight)
    );

    // result queue
    gbb_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .i_ready (i_m_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_data  (q_data),
        .o_count (q_count)
    );

    assign o_m_axis_tdata = q_data.gray_value;
    assign o_m_axis_tlast = q_data.end_of_row;
    assign o_m_axis_tuser = q_data.end_of_frame;

    // frame end on the output side
    assign out_eof = o_m_axis_tvalid && o_m_axis_tuser;

    // checks
    `GBB_ASSERT_HOLDS(a_queue_room, int'(occupancy) <= OUTQ_DEPTH, "result queue overrun")
    `GBB_ASSERT_NEXT(a_cfg_holdoff, cfg_we, !o_s_axis_tready, "request taken after write")
    `GBB_ASSERT_IMPLIES(a_frame_end_row, out_eof, o_m_axis_tlast, "frame end off row end")

endmodule
